@@ rtl/core/cbe_pkg.sv @@
// Shared types, codes and an arithmetic helper of the cubic B-spline evaluator.
package cbe_pkg;

    localparam int MAX_KNOTS_DEFAULT = 64;

    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 6;
    localparam int VALUE_W  = 32;
    localparam int KCOUNT_W = 7;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 32;

    localparam logic [KCOUNT_W-1:0] KCOUNT_RESET = 7'd8;

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_KNOT = 2'd0,
        CMD_WR_COEF = 2'd1,
        CMD_EVAL    = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    // Q16.16 one.
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    // Saturates a 50-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        begin
            hi = 50'sh0_0000_7FFF_FFFF;
            lo = -50'sh0_0000_8000_0000;
            if (v > hi) begin
                sat32 = 32'sh7FFF_FFFF;
            end else if (v < lo) begin
                sat32 = 32'sh8000_0000;
            end else begin
                sat32 = v[31:0];
            end
        end
    endfunction

endpackage

@@ rtl/core/cubic_bspline_evaluator_unit.sv @@
// Cubic B-spline evaluator: knot scan, Cox-de Boor triangle and dot product on shared units.
// An evaluate beat scans the knots for j, the position of the first knot not below x, reads the
// distances, and runs each basis step through the bit-serial divider and the shared multiplier.
// A point outside the interior span returns flagged, with a zero value, right after the scan.
// One beat is in work at a time, and a finished result waits in the output register until taken.
// Synchronous active-low reset clears the sequencer and output valid and sets knot_count to 8.
module cubic_bspline_evaluator_unit #(
    parameter int MAX_KNOTS = cbe_pkg::MAX_KNOTS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration: knot_count.
    input  logic                          cfg_wr_en,
    input  logic [cbe_pkg::KCOUNT_W-1:0]  cfg_wr_data,
    // Input beats.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cbe_pkg::S_DATA_W-1:0]  s_tdata,   // [5:0] index, [37:6] value, [39:38] zero
    input  logic [cbe_pkg::CMD_W-1:0]     s_tuser,   // [1:0] command
    // Result beats.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cbe_pkg::M_DATA_W-1:0]  m_tdata,   // [31:0] spline_value
    output logic                          m_tuser    // [0] out_of_range
);

    localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
    localparam int JW = $clog2(MAX_KNOTS + 2);
    localparam int CW = (JW > cbe_pkg::KCOUNT_W) ? JW : cbe_pkg::KCOUNT_W;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN_A, S_SCAN_C, S_CHECK, S_DIST_A, S_DIST_C,
        S_DEN, S_DIV, S_DIVFIX, S_MUL_R, S_UPD_R, S_MUL_L, S_UPD_L,
        S_DOT_A, S_DOT_M, S_DOT_ACC, S_OUT
    } state_t;

    state_t state_reg;

    // Tables, one read port each with registered read data.
    logic signed [31:0] knot_mem [MAX_KNOTS];
    logic signed [31:0] coef_mem [MAX_KNOTS];
    logic signed [31:0] knot_q_reg;
    logic signed [31:0] coef_q_reg;
    logic [AW-1:0]      knot_raddr;
    logic [AW-1:0]      coef_raddr;

    logic [cbe_pkg::KCOUNT_W-1:0] knot_count_reg;

    logic signed [31:0] x_reg;
    logic [JW-1:0]      j_reg;
    logic [2:0]         k_reg;
    logic [1:0]         q_reg;
    logic [1:0]         r_reg;
    logic signed [31:0] rdel_reg [3];
    logic signed [31:0] ldel_reg [3];
    logic signed [31:0] val_reg  [4];
    logic signed [31:0] saved_reg;
    logic signed [31:0] term_reg;
    logic signed [63:0] prod_reg;
    logic signed [49:0] acc_reg;
    logic [47:0]        num_reg;
    logic [32:0]        rem_reg;
    logic [32:0]        den_mag_reg;
    logic               neg_reg;
    logic [5:0]         cnt_reg;

    // Finished result, held here until the output register is free.
    logic [31:0]        res_value_reg;
    logic               res_flag_reg;

    logic               m_tvalid_reg;
    logic [31:0]        m_tdata_reg;
    logic               m_tuser_reg;

    // Input beat fields.
    logic [cbe_pkg::INDEX_W-1:0] in_index;
    logic signed [31:0]          in_value;
    cbe_pkg::cmd_t               in_cmd;
    logic                        s_acc;
    logic                        idx_ok;

    assign in_index = s_tdata[5:0];
    assign in_value = s_tdata[37:6];
    assign in_cmd   = cbe_pkg::cmd_t'(s_tuser);
    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign idx_ok   = (int'(in_index) < MAX_KNOTS);

    // Effective knot count: min(knot_count, MAX_KNOTS).
    logic [CW-1:0] kc_ext;
    logic [JW-1:0] nk;
    assign kc_ext = CW'(knot_count_reg);
    assign nk     = (kc_ext > CW'(MAX_KNOTS)) ? JW'(MAX_KNOTS) : JW'(kc_ext);

    logic [JW:0] j_ext;
    logic [JW:0] nk_ext;
    logic        span_bad;
    assign j_ext    = {1'b0, j_reg};
    assign nk_ext   = {1'b0, nk};
    assign span_bad = (j_ext < (JW+1)'(5)) || ((j_ext + (JW+1)'(3)) > nk_ext);

    // Table read addresses follow the sequencer.
    logic [JW:0] kaddr_full;
    logic [JW:0] caddr_full;
    always_comb begin
        if (state_reg == S_DIST_A) begin
            if (k_reg < 3'd3) begin
                kaddr_full = j_ext - (JW+1)'(1) + (JW+1)'(k_reg);
            end else begin
                kaddr_full = j_ext - (JW+1)'(2) - (JW+1)'(k_reg - 3'd3);
            end
        end else begin
            kaddr_full = j_ext - (JW+1)'(1);
        end
        caddr_full = j_ext - (JW+1)'(5) + (JW+1)'(k_reg);
    end
    assign knot_raddr = kaddr_full[AW-1:0];
    assign coef_raddr = caddr_full[AW-1:0];

    always_ff @(posedge aclk) begin
        if (s_acc && idx_ok && (in_cmd == cbe_pkg::CMD_WR_KNOT)) begin
            knot_mem[AW'(in_index)] <= in_value;
        end
        knot_q_reg <= knot_mem[knot_raddr];
    end

    always_ff @(posedge aclk) begin
        if (s_acc && idx_ok && (in_cmd == cbe_pkg::CMD_WR_COEF)) begin
            coef_mem[AW'(in_index)] <= in_value;
        end
        coef_q_reg <= coef_mem[coef_raddr];
    end

    // Shared multiplier: operands picked by the sequencer, product always registered.
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic [1:0]         lidx;
    assign lidx = q_reg - 2'd1 - r_reg;
    always_comb begin
        unique case (state_reg)
            S_MUL_R: begin
                mul_a = rdel_reg[r_reg];
                mul_b = term_reg;
            end
            S_MUL_L: begin
                mul_a = ldel_reg[lidx];
                mul_b = term_reg;
            end
            default: begin
                mul_a = val_reg[k_reg[1:0]];
                mul_b = coef_q_reg;
            end
        endcase
    end

    logic signed [47:0] prod_sh;
    assign prod_sh = prod_reg[63:16];   // floor of product / 2^16

    // Denominator and division operands.
    logic signed [32:0] den;
    logic [32:0]        den_mag;
    logic [47:0]        num_full;
    logic [47:0]        num_mag;
    assign den      = 33'(rdel_reg[r_reg]) + 33'(ldel_reg[lidx]);
    assign den_mag  = den[32] ? (33'd0 - den) : den;
    assign num_full = {val_reg[r_reg], 16'h0000};
    assign num_mag  = val_reg[r_reg][31] ? (48'd0 - num_full) : num_full;

    // One restoring step of the bit-serial divider.
    logic [33:0] rem_sh;
    logic        qbit;
    logic [33:0] rem_sub;
    assign rem_sh  = {rem_reg, num_reg[47]};
    assign qbit    = (rem_sh >= {1'b0, den_mag_reg});
    assign rem_sub = rem_sh - {1'b0, den_mag_reg};

    // Quotient sign and saturation.
    logic signed [31:0] term_sat;
    always_comb begin
        if (!neg_reg) begin
            term_sat = (num_reg > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : num_reg[31:0];
        end else begin
            term_sat = (num_reg > 48'h0000_8000_0000) ? 32'sh8000_0000
                                                      : (32'd0 - num_reg[31:0]);
        end
    end

    logic signed [31:0] dist_val;
    logic signed [31:0] upd_r;
    logic signed [31:0] saved_next;
    logic signed [49:0] acc_next;
    always_comb begin
        if (k_reg < 3'd3) begin
            dist_val = cbe_pkg::sat32(50'(knot_q_reg) - 50'(x_reg));
        end else begin
            dist_val = cbe_pkg::sat32(50'(x_reg) - 50'(knot_q_reg));
        end
        upd_r      = cbe_pkg::sat32(50'(saved_reg) + 50'(prod_sh));
        saved_next = cbe_pkg::sat32(50'(prod_sh));
        acc_next   = acc_reg + 50'(prod_sh);
    end

    logic out_load;
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_tvalid_reg   <= 1'b0;
            knot_count_reg <= cbe_pkg::KCOUNT_RESET;
        end else begin
            if (cfg_wr_en) begin
                knot_count_reg <= cfg_wr_data;
            end
            // The output register takes a new result only once the previous one is gone.
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= res_value_reg;
                m_tuser_reg  <= res_flag_reg;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            prod_reg <= mul_a * mul_b;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc && (in_cmd == cbe_pkg::CMD_EVAL)) begin
                        x_reg     <= in_value;
                        j_reg     <= JW'(1);
                        state_reg <= S_SCAN_A;
                    end
                end
                S_SCAN_A: begin
                    state_reg <= (j_reg > nk) ? S_CHECK : S_SCAN_C;
                end
                S_SCAN_C: begin
                    if (knot_q_reg >= x_reg) begin
                        state_reg <= S_CHECK;
                    end else begin
                        j_reg     <= j_reg + JW'(1);
                        state_reg <= S_SCAN_A;
                    end
                end
                S_CHECK: begin
                    if (span_bad) begin
                        res_value_reg <= 32'd0;
                        res_flag_reg  <= 1'b1;
                        state_reg     <= S_OUT;
                    end else begin
                        k_reg      <= 3'd0;
                        val_reg[0] <= cbe_pkg::Q_ONE;
                        state_reg  <= S_DIST_A;
                    end
                end
                S_DIST_A: begin
                    state_reg <= S_DIST_C;
                end
                S_DIST_C: begin
                    if (k_reg < 3'd3) begin
                        rdel_reg[k_reg[1:0]] <= dist_val;
                    end else begin
                        ldel_reg[2'(k_reg - 3'd3)] <= dist_val;
                    end
                    if (k_reg == 3'd5) begin
                        q_reg     <= 2'd1;
                        r_reg     <= 2'd0;
                        saved_reg <= 32'sd0;
                        state_reg <= S_DEN;
                    end else begin
                        k_reg     <= k_reg + 3'd1;
                        state_reg <= S_DIST_A;
                    end
                end
                S_DEN: begin
                    if (den == 33'sd0) begin
                        res_value_reg <= 32'd0;
                        res_flag_reg  <= 1'b1;
                        state_reg     <= S_OUT;
                    end else begin
                        den_mag_reg <= den_mag;
                        num_reg     <= num_mag;
                        neg_reg     <= den[32] ^ val_reg[r_reg][31];
                        rem_reg     <= 33'd0;
                        cnt_reg     <= 6'd47;
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV: begin
                    rem_reg <= qbit ? rem_sub[32:0] : rem_sh[32:0];
                    num_reg <= {num_reg[46:0], qbit};
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0) begin
                        state_reg <= S_DIVFIX;
                    end
                end
                S_DIVFIX: begin
                    term_reg  <= term_sat;
                    state_reg <= S_MUL_R;
                end
                S_MUL_R: begin
                    state_reg <= S_UPD_R;
                end
                S_UPD_R: begin
                    val_reg[r_reg] <= upd_r;
                    state_reg      <= S_MUL_L;
                end
                S_MUL_L: begin
                    state_reg <= S_UPD_L;
                end
                S_UPD_L: begin
                    if (r_reg == q_reg - 2'd1) begin
                        val_reg[q_reg] <= saved_next;
                        saved_reg      <= 32'sd0;
                        r_reg          <= 2'd0;
                        if (q_reg == 2'd3) begin
                            k_reg     <= 3'd0;
                            acc_reg   <= 50'sd0;
                            state_reg <= S_DOT_A;
                        end else begin
                            q_reg     <= q_reg + 2'd1;
                            state_reg <= S_DEN;
                        end
                    end else begin
                        saved_reg <= saved_next;
                        r_reg     <= r_reg + 2'd1;
                        state_reg <= S_DEN;
                    end
                end
                S_DOT_A: begin
                    state_reg <= S_DOT_M;
                end
                S_DOT_M: begin
                    state_reg <= S_DOT_ACC;
                end
                S_DOT_ACC: begin
                    acc_reg <= acc_next;
                    if (k_reg == 3'd3) begin
                        res_value_reg <= cbe_pkg::sat32(acc_next);
                        res_flag_reg  <= 1'b0;
                        state_reg     <= S_OUT;
                    end else begin
                        k_reg     <= k_reg + 3'd1;
                        state_reg <= S_DOT_A;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A flagged result always carries a zero value.
    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("flagged result with nonzero value");

    // The divider never runs on a zero divisor.
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (den_mag_reg != 33'd0))
        else $error("division by zero");

    // Distance reads only happen for an interior span.
    a_span_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIST_A) |-> !span_bad)
        else $error("distance read outside interior span");

    // An accepted evaluate beat leaves the idle state.
    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (in_cmd == cbe_pkg::CMD_EVAL)) |=> (state_reg != S_IDLE))
        else $error("evaluate beat dropped");

endmodule

@@ bench/spline_checker.sv @@
// Watches the B-spline evaluator's channels, predicts each spline value and compares results.
`timescale 1ns / 100ps

module spline_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [cbe_pkg::KCOUNT_W-1:0]  cfg_wr_data,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [cbe_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [cbe_pkg::CMD_W-1:0]     s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [cbe_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          m_tuser,
    output int                            pending,
    output int                            fail_count
);
    import cbe_pkg::*;

    typedef struct packed {
        logic signed [31:0] spline_value;
        logic               out_of_range;
    } spline_result_t;

    longint                  knot_mem [64];
    longint                  coef_mem [64];
    logic [KCOUNT_W-1:0]     knots_in_use;
    spline_result_t          expected_q [$];

    initial begin
        fail_count = 0;
        pending    = 0;
        knots_in_use = KCOUNT_RESET;
        foreach (knot_mem[i]) begin
            knot_mem[i] = 0;
            coef_mem[i] = 0;
        end
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Floor of a Q16.16 product: arithmetic shift of a signed value rounds down.
    function automatic longint fix_mul(input longint a, input longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic spline_result_t spline_at(input longint x);
        spline_result_t res;
        longint nk, j, den, term, saved, acc;
        longint rdist [3];
        longint ldist [3];
        longint basis [4];
        begin
            res.spline_value = '0;
            res.out_of_range = 1'b1;
            nk = (knots_in_use > 64) ? 64 : knots_in_use;
            for (j = 1; j <= nk; j++)
                if (knot_mem[j-1] >= x) break;
            if (j < 5 || j > nk - 3) return res;
            for (int q = 0; q < 3; q++) begin
                rdist[q] = clamp32(knot_mem[j-1+q] - x);
                ldist[q] = clamp32(x - knot_mem[j-2-q]);
            end
            basis[0] = 65536;
            for (int q = 1; q <= 3; q++) begin
                saved = 0;
                for (int r = 0; r < q; r++) begin
                    den = rdist[r] + ldist[q-1-r];
                    // A repeated knot collapses the span and flags the point.
                    if (den == 0) return res;
                    term = clamp32((basis[r] * 65536) / den);
                    basis[r] = clamp32(saved + fix_mul(rdist[r], term));
                    saved = clamp32(fix_mul(ldist[q-1-r], term));
                end
                basis[q] = saved;
            end
            acc = 0;
            for (int q = 0; q < 4; q++)
                acc += fix_mul(basis[q], coef_mem[j-5+q]);
            res.spline_value = clamp32(acc);
            res.out_of_range = 1'b0;
            return res;
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        spline_result_t want;
        cmd_t           cmd;
        logic [5:0]     idx;
        logic signed [31:0] val;
        if (!aresetn) begin
            knots_in_use = KCOUNT_RESET;
        end else begin
            if (cfg_wr_en) knots_in_use = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h/%b", m_tdata, m_tuser));
                end else begin
                    want = expected_q.pop_front();
                    if (m_tdata !== want.spline_value)
                        report_mismatch($sformatf("spline_value %h, want %h",
                                                  m_tdata, want.spline_value));
                    if (m_tuser !== want.out_of_range)
                        report_mismatch($sformatf("out_of_range %b, want %b",
                                                  m_tuser, want.out_of_range));
                end
            end
            if (s_tvalid && s_tready) begin
                cmd = cmd_t'(s_tuser);
                idx = s_tdata[5:0];
                val = s_tdata[37:6];
                case (cmd)
                    CMD_WR_KNOT: knot_mem[idx] = val;
                    CMD_WR_COEF: coef_mem[idx] = val;
                    CMD_EVAL:    expected_q.push_back(spline_at(val));
                    default: ;
                endcase
            end
        end
        pending = expected_q.size();
    end

endmodule

@@ bench/testbench.sv @@
// Top of the B-spline evaluator bench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 100ps

module testbench;
    import cbe_pkg::*;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [KCOUNT_W-1:0]   cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;     // [5:0] index, [37:6] value, [39:38] zero
    logic [CMD_W-1:0]      s_tuser;     // [1:0] command
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;     // [31:0] spline_value
    logic                  m_tuser;     // [0] out_of_range
    int                    pending;
    int                    fail_count;

    // The bench keeps its own view of the knots only to aim evaluation points at spans.
    longint                knot_view [64];
    int                    span_knots;
    bit                    idle_on;

    cubic_bspline_evaluator_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    spline_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .pending(pending), .fail_count(fail_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // The run cannot legitimately take this long.
    initial begin
        #30ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: after every accepted result a stall of random length is drawn,
    // and stalls are skipped entirely while the sender runs without gaps.
    int stall_left;
    initial begin
        m_tready   = 1'b0;
        stall_left = 0;
    end
    always @(posedge aclk) begin
        logic ready_next;
        if (m_tvalid && m_tready)
            stall_left = idle_on ? $urandom_range(0, 13) : 0;
        if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
        end else begin
            ready_next = 1'b1;
        end
        m_tready <= ready_next;
    end

    // Offers one beat and holds it until accepted. A gap is drawn afterwards, so valid
    // stays high into the next beat when no gap follows.
    task automatic put_beat(input cmd_t cmd, input logic [5:0] idx, input logic [31:0] val);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, val, idx};
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_WR_KNOT) knot_view[idx] = $signed(val);
        gap = idle_on ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Register writes happen only with the block idle; the extra cycles cover a write
    // beat that may still be settling after the last result.
    task automatic set_knot_count(input logic [KCOUNT_W-1:0] count);
        hold_until_drained();
        repeat (16) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        span_knots = (count > 64) ? 64 : count;
    endtask

    function automatic logic [31:0] aimed_point();
        longint x;
        int     k;
        k = $urandom_range(0, span_knots - 1);
        case ($urandom_range(0, 9))
            7:       x = knot_view[k];
            8:       x = $signed($urandom());
            9:       x = $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
            default: x = knot_view[k] - $urandom_range(0, 131072);
        endcase
        if (x < -64'sd2147483648) x = -64'sd2147483648;
        return x[31:0];
    endfunction

    task automatic random_beat();
        int     pick;
        int     idx;
        longint v;
        pick = $urandom_range(0, 99);
        idx  = $urandom_range(0, 63);
        if (pick < 68) begin
            put_beat(CMD_EVAL, 6'd0, aimed_point());
        end else if (pick < 82) begin
            // Mostly small nudges so the knots stay close to ascending order.
            if ($urandom_range(0, 4) == 0) v = $signed($urandom());
            else v = knot_view[idx] + $signed($urandom_range(0, 65536)) - 32768;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            put_beat(CMD_WR_KNOT, idx[5:0], v[31:0]);
        end else if (pick < 96) begin
            put_beat(CMD_WR_COEF, idx[5:0],
                     $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 8 << 16));
        end else begin
            put_beat(CMD_NONE, idx[5:0], $urandom());
        end
    endtask

    initial begin
        logic [KCOUNT_W-1:0] phase_counts [8];
        longint knot_pos;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = CMD_NONE;
        idle_on     = 1'b1;
        span_knots  = 8;
        phase_counts = '{7'd8, 7'd64, 7'd20, 7'd127, 7'd5, 7'd40, 7'd8, 7'd64};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Load every table entry before anything is evaluated. Knots ascend with an
        // occasional repeat, which drives the zero-denominator case.
        knot_pos = -64'sd20 * 65536;
        for (int i = 0; i < 64; i++) begin
            if ($urandom_range(0, 9) != 0)
                knot_pos += $urandom_range(0, 3) * 65536 + $urandom_range(1, 65535);
            put_beat(CMD_WR_KNOT, i[5:0], knot_pos[31:0]);
            put_beat(CMD_WR_COEF, i[5:0], $urandom());
        end

        // Directed beats: the value extremes, exact knots, and ignored commands.
        put_beat(CMD_EVAL, 6'd0, 32'h8000_0000);
        put_beat(CMD_EVAL, 6'd0, 32'h7FFF_FFFF);
        put_beat(CMD_EVAL, 6'd0, knot_view[4][31:0]);
        put_beat(CMD_EVAL, 6'd0, knot_view[5][31:0] - 32'd1);
        put_beat(CMD_NONE, 6'd63, 32'hFFFF_FFFF);
        put_beat(CMD_WR_COEF, 6'd5, 32'h7FFF_FFFF);
        put_beat(CMD_WR_COEF, 6'd6, 32'h8000_0000);
        put_beat(CMD_EVAL, 6'd0, knot_view[6][31:0] - 32'h8000);
        // A run of three equal knots collapses every span around it.
        put_beat(CMD_WR_KNOT, 6'd6, knot_view[5][31:0]);
        put_beat(CMD_WR_KNOT, 6'd7, knot_view[5][31:0]);
        put_beat(CMD_EVAL, 6'd0, knot_view[5][31:0]);
        put_beat(CMD_EVAL, 6'd0, knot_view[5][31:0] - 32'd100);
        put_beat(CMD_WR_KNOT, 6'd63, 32'h7FFF_FFFF);
        put_beat(CMD_WR_KNOT, 6'd0, 32'h8000_0000);
        put_beat(CMD_EVAL, 6'd0, 32'h0000_0000);

        foreach (phase_counts[p]) begin
            set_knot_count(phase_counts[p]);
            put_beat(CMD_EVAL, 6'd0, knot_view[span_knots - 4][31:0]);
            for (int n = 0; n < 75; n++) begin
                // Every 30 beats the gaps may switch off for a back-to-back stretch.
                if (n % 30 == 0) idle_on = $urandom_range(0, 2) != 0;
                if (p == 3 && n == 37) hold_until_drained();
                random_beat();
            end
        end

        s_tvalid <= 1'b0;
        idle_on = 1'b1;
        while (pending != 0) @(posedge aclk);
        repeat (500) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ cubic_bspline_evaluator_unit.f @@
rtl/core/cbe_pkg.sv
rtl/core/cubic_bspline_evaluator_unit.sv
bench/spline_checker.sv
bench/testbench.sv
